// File: rtl/cci_pkg.sv
// shared constants and transaction types for the circle intersection unit
package cci_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int RADIUS_WIDTH = 31;
  localparam int MINSEP_WIDTH = 16;
  localparam logic [MINSEP_WIDTH-1:0] MINSEP_RESET = 16'd7;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]  center_a_x;
    logic [COORD_WIDTH-1:0]  center_a_y;
    logic [COORD_WIDTH-1:0]  center_b_x;
    logic [COORD_WIDTH-1:0]  center_b_y;
    logic [RADIUS_WIDTH-1:0] radius_a;
    logic [RADIUS_WIDTH-1:0] radius_b;
  } cci_in_t;

  typedef struct packed {
    logic                   found;
    logic [COORD_WIDTH-1:0] first_x;
    logic [COORD_WIDTH-1:0] first_y;
    logic [COORD_WIDTH-1:0] second_x;
    logic [COORD_WIDTH-1:0] second_y;
  } cci_out_t;

endpackage

// File: rtl/circle_circle_intersection_unit.sv
// circle-circle intersection pipeline, top level
//
//  channel   ports                          handshake
//  -------   -----------------------------  ------------------------------------
//  input     start, busy, in_data           taken when start=1 and busy=0
//  result    out_strobe, out_data           valid for one cycle, no back-pressure
//  config    cfg_wr_en, cfg_wr_data         min_separation written when enable=1
//
// one transaction enters every cycle; busy is always low
// the chain of bit-serial units holds 33 root steps for d, 32 divide steps for a,
// 31 root steps for h and 32 divide steps for the four point quotients, plus
// thirteen capture, arithmetic and output stages; reset (synchronous, active low)
// clears only valid bits and min_separation
// the receiver cannot stall, so the pipe never holds and nothing is dropped
module circle_circle_intersection_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  cci_pkg::cci_in_t                      in_data,
  output logic                                  out_strobe,
  output cci_pkg::cci_out_t                     out_data,
  input  logic                                  cfg_wr_en,
  input  logic [cci_pkg::MINSEP_WIDTH-1:0]      cfg_wr_data
);
  import cci_pkg::*;

  // widths
  localparam int CW   = COORD_WIDTH;
  localparam int RW   = RADIUS_WIDTH;
  localparam int DXW  = CW + 1;          // centre difference
  localparam int DW   = CW + 1;          // centre distance
  localparam int SQW  = 2 * DW;          // squared distance
  localparam int BN   = DW;              // root steps for d
  localparam int QA   = RW + 1;          // quotient bits of a
  localparam int AW   = QA + 1;          // signed a
  localparam int NMW0 = ((2 * DW > 2 * RW) ? 2 * DW : 2 * RW) + 1;
  localparam int NMW  = (NMW0 > QA + DW + 1) ? NMW0 : QA + DW + 1;
  localparam int NW   = NMW + 1;         // signed numerator of a
  localparam int UW   = 2 * QA;          // a squared
  localparam int HRW  = 2 * RW;          // radicand of h
  localparam int FN   = RW;              // root steps for h
  localparam int PW   = AW + DXW;        // product width
  localparam int MW   = PW + 1;          // sum width
  localparam int QB   = RW + 1;          // quotient bits of each point offset
  localparam int SW   = ((CW > QB + 1) ? CW : QB + 1) + 1;

  localparam logic signed [SW-1:0] CMAX = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [DXW-1:0] dx;
    logic [DXW-1:0] dy;
    logic [RW-1:0]  r1;
    logic [RW-1:0]  r2;
  } geo_t;

  typedef struct packed {
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [DXW-1:0] dx;
    logic [DXW-1:0] dy;
    logic [RW-1:0]  r1;
    logic [DW-1:0]  d;
    logic           found;
  } csd_t;

  typedef struct packed {
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [DXW-1:0] dx;
    logic [DXW-1:0] dy;
    logic [RW-1:0]  r1;
    logic [HRW-1:0] r1sq;
    logic [DW-1:0]  d;
    logic           found;
    logic           neg;
    logic           ovf;
  } dsd_t;

  typedef struct packed {
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [DXW-1:0] dx;
    logic [DXW-1:0] dy;
    logic [DW-1:0]  d;
    logic [AW-1:0]  a;
    logic           found;
  } fsd_t;

  typedef struct packed {
    logic [CW-1:0] ax;
    logic [CW-1:0] ay;
    logic [DW-1:0] d;
    logic [3:0]    neg;
    logic          found;
  } hsd_t;

  // configuration register
  logic [MINSEP_WIDTH-1:0] minsep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minsep_r <= MINSEP_RESET;
    end else if (cfg_wr_en) begin
      minsep_r <= cfg_wr_data;
    end
  end

  // the pipe never stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage a1: capture and centre differences
  logic           a1_vld_r;
  geo_t           a1_geo_r;
  geo_t           a1_geo_nxt;

  always_comb begin
    a1_geo_nxt.ax = in_data.center_a_x;
    a1_geo_nxt.ay = in_data.center_a_y;
    a1_geo_nxt.dx = {in_data.center_b_x[CW-1], in_data.center_b_x}
                  - {in_data.center_a_x[CW-1], in_data.center_a_x};
    a1_geo_nxt.dy = {in_data.center_b_y[CW-1], in_data.center_b_y}
                  - {in_data.center_a_y[CW-1], in_data.center_a_y};
    a1_geo_nxt.r1 = in_data.radius_a;
    a1_geo_nxt.r2 = in_data.radius_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_vld_r <= 1'b0;
    end else begin
      a1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    a1_geo_r <= a1_geo_nxt;
  end

  // stage a2: squares of the differences
  logic                  a2_vld_r;
  geo_t                  a2_geo_r;
  logic signed [SQW-1:0] a2_dxsq_r;
  logic signed [SQW-1:0] a2_dysq_r;
  logic signed [SQW-1:0] a2_dxsq_nxt;
  logic signed [SQW-1:0] a2_dysq_nxt;

  always_comb begin
    a2_dxsq_nxt = $signed(a1_geo_r.dx) * $signed(a1_geo_r.dx);
    a2_dysq_nxt = $signed(a1_geo_r.dy) * $signed(a1_geo_r.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_vld_r <= 1'b0;
    end else begin
      a2_vld_r <= a1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a2_geo_r  <= a1_geo_r;
    a2_dxsq_r <= a2_dxsq_nxt;
    a2_dysq_r <= a2_dysq_nxt;
  end

  // ---------------------------------------------------------------------------
  // floor square root of dx^2 + dy^2, two radicand bits per stage
  logic            sq_vld_r  [0:BN];
  geo_t            sq_geo_r  [0:BN];
  logic [SQW-1:0]  sq_rad_r  [0:BN];
  logic [DW-1:0]   sq_root_r [0:BN];
  logic [DW+1:0]   sq_rem_r  [0:BN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= a2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_geo_r[0]  <= a2_geo_r;
    sq_rad_r[0]  <= a2_dxsq_r + a2_dysq_r;
    sq_root_r[0] <= '0;
    sq_rem_r[0]  <= '0;
  end

  for (genvar i = 1; i <= BN; i++) begin : g_dist_root
    logic [DW+3:0] tmp;
    logic [DW+3:0] trial;
    logic [DW+3:0] diff;
    logic          ge;

    always_comb begin
      tmp   = {sq_rem_r[i-1], sq_rad_r[i-1][SQW-1 -: 2]};
      trial = {2'b00, sq_root_r[i-1], 2'b01};
      diff  = tmp - trial;
      ge    = (tmp >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else begin
        sq_vld_r[i] <= sq_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      sq_geo_r[i]  <= sq_geo_r[i-1];
      sq_rad_r[i]  <= {sq_rad_r[i-1][SQW-3:0], 2'b00};
      sq_root_r[i] <= {sq_root_r[i-1][DW-2:0], ge};
      sq_rem_r[i]  <= ge ? diff[DW+1:0] : tmp[DW+1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage c1: range checks and squares for a
  logic           c1_vld_r;
  csd_t           c1_sd_r;
  logic [SQW-1:0] c1_dsq_r;
  logic [HRW-1:0] c1_r1sq_r;
  logic [HRW-1:0] c1_r2sq_r;
  csd_t           c1_sd_nxt;
  logic [DW-1:0]  c1_rsum;

  always_comb begin
    c1_rsum         = DW'(sq_geo_r[BN].r1) + DW'(sq_geo_r[BN].r2);
    c1_sd_nxt.ax    = sq_geo_r[BN].ax;
    c1_sd_nxt.ay    = sq_geo_r[BN].ay;
    c1_sd_nxt.dx    = sq_geo_r[BN].dx;
    c1_sd_nxt.dy    = sq_geo_r[BN].dy;
    c1_sd_nxt.r1    = sq_geo_r[BN].r1;
    c1_sd_nxt.d     = sq_root_r[BN];
    // too far apart, or centres counted as coincident
    c1_sd_nxt.found = (sq_root_r[BN] <= c1_rsum) && (sq_root_r[BN] > DW'(minsep_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
    end else begin
      c1_vld_r <= sq_vld_r[BN];
    end
  end

  always_ff @(posedge clk) begin
    c1_sd_r   <= c1_sd_nxt;
    c1_dsq_r  <= sq_root_r[BN] * sq_root_r[BN];
    c1_r1sq_r <= sq_geo_r[BN].r1 * sq_geo_r[BN].r1;
    c1_r2sq_r <= sq_geo_r[BN].r2 * sq_geo_r[BN].r2;
  end

  // stage c2: numerator r1^2 - r2^2 + d^2
  logic           c2_vld_r;
  csd_t           c2_sd_r;
  logic [HRW-1:0] c2_r1sq_r;
  logic [NW-1:0]  c2_num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_vld_r <= 1'b0;
    end else begin
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c2_sd_r   <= c1_sd_r;
    c2_r1sq_r <= c1_r1sq_r;
    c2_num_r  <= NW'(c1_dsq_r) + NW'(c1_r1sq_r) - NW'(c1_r2sq_r);
  end

  // stage c3: sign and magnitude
  logic           c3_vld_r;
  csd_t           c3_sd_r;
  logic [HRW-1:0] c3_r1sq_r;
  logic           c3_neg_r;
  logic [NMW-1:0] c3_mag_r;
  logic [NW-1:0]  c3_negated;

  always_comb begin
    c3_negated = -c2_num_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_vld_r <= 1'b0;
    end else begin
      c3_vld_r <= c2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c3_sd_r   <= c2_sd_r;
    c3_r1sq_r <= c2_r1sq_r;
    c3_neg_r  <= c2_num_r[NW-1];
    c3_mag_r  <= c2_num_r[NW-1] ? c3_negated[NMW-1:0] : c2_num_r[NMW-1:0];
  end

  // ---------------------------------------------------------------------------
  // a = num / 2d, one quotient bit per stage; a quotient that cannot fit
  // in QA bits is already larger than r1
  logic          ad_vld_r [0:QA];
  dsd_t          ad_sd_r  [0:QA];
  logic [DW:0]   ad_rem_r [0:QA];
  logic [QA-1:0] ad_low_r [0:QA];
  dsd_t          ad_sd_nxt;
  logic [NMW-1:0] ad_hi;

  always_comb begin
    ad_hi           = c3_mag_r >> QA;
    ad_sd_nxt.ax    = c3_sd_r.ax;
    ad_sd_nxt.ay    = c3_sd_r.ay;
    ad_sd_nxt.dx    = c3_sd_r.dx;
    ad_sd_nxt.dy    = c3_sd_r.dy;
    ad_sd_nxt.r1    = c3_sd_r.r1;
    ad_sd_nxt.r1sq  = c3_r1sq_r;
    ad_sd_nxt.d     = c3_sd_r.d;
    ad_sd_nxt.found = c3_sd_r.found;
    ad_sd_nxt.neg   = c3_neg_r;
    ad_sd_nxt.ovf   = (ad_hi >= NMW'({c3_sd_r.d, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_vld_r[0] <= 1'b0;
    end else begin
      ad_vld_r[0] <= c3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    ad_sd_r[0]  <= ad_sd_nxt;
    ad_rem_r[0] <= c3_mag_r[QA+DW:QA];
    ad_low_r[0] <= c3_mag_r[QA-1:0];
  end

  for (genvar i = 1; i <= QA; i++) begin : g_a_div
    logic [DW+1:0] tmp;
    logic [DW+1:0] dd;
    logic [DW+1:0] diff;
    logic          ge;

    always_comb begin
      tmp  = {ad_rem_r[i-1], ad_low_r[i-1][QA-1]};
      dd   = {1'b0, ad_sd_r[i-1].d, 1'b0};
      diff = tmp - dd;
      ge   = (tmp >= dd);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ad_vld_r[i] <= 1'b0;
      end else begin
        ad_vld_r[i] <= ad_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      ad_sd_r[i]  <= ad_sd_r[i-1];
      ad_rem_r[i] <= ge ? diff[DW:0] : tmp[DW:0];
      ad_low_r[i] <= {ad_low_r[i-1][QA-2:0], ge};
    end
  end

  // ---------------------------------------------------------------------------
  // stage e1: signed a, containment check, a^2
  logic           e1_vld_r;
  fsd_t           e1_sd_r;
  logic [HRW-1:0] e1_r1sq_r;
  logic [UW-1:0]  e1_uasq_r;
  fsd_t           e1_sd_nxt;
  logic [QA-1:0]  e1_q;
  logic [AW-1:0]  e1_qext;

  always_comb begin
    e1_q            = ad_low_r[QA];
    e1_qext         = {1'b0, e1_q};
    e1_sd_nxt.ax    = ad_sd_r[QA].ax;
    e1_sd_nxt.ay    = ad_sd_r[QA].ay;
    e1_sd_nxt.dx    = ad_sd_r[QA].dx;
    e1_sd_nxt.dy    = ad_sd_r[QA].dy;
    e1_sd_nxt.d     = ad_sd_r[QA].d;
    e1_sd_nxt.a     = ad_sd_r[QA].neg ? -e1_qext : e1_qext;
    // one circle inside the other shows as |a| > r1
    e1_sd_nxt.found = ad_sd_r[QA].found & ~ad_sd_r[QA].ovf
                    & (e1_q <= QA'(ad_sd_r[QA].r1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= ad_vld_r[QA];
    end
  end

  always_ff @(posedge clk) begin
    e1_sd_r   <= e1_sd_nxt;
    e1_r1sq_r <= ad_sd_r[QA].r1sq;
    e1_uasq_r <= e1_q * e1_q;
  end

  // ---------------------------------------------------------------------------
  // h = floor sqrt(r1^2 - a^2)
  logic           hs_vld_r  [0:FN];
  fsd_t           hs_sd_r   [0:FN];
  logic [HRW-1:0] hs_rad_r  [0:FN];
  logic [RW-1:0]  hs_root_r [0:FN];
  logic [RW+1:0]  hs_rem_r  [0:FN];
  logic [UW-1:0]  hs_rad_nxt;

  always_comb begin
    hs_rad_nxt = UW'(e1_r1sq_r) - e1_uasq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_vld_r[0] <= 1'b0;
    end else begin
      hs_vld_r[0] <= e1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    hs_sd_r[0]   <= e1_sd_r;
    hs_rad_r[0]  <= hs_rad_nxt[HRW-1:0];
    hs_root_r[0] <= '0;
    hs_rem_r[0]  <= '0;
  end

  for (genvar i = 1; i <= FN; i++) begin : g_h_root
    logic [RW+3:0] tmp;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    always_comb begin
      tmp   = {hs_rem_r[i-1], hs_rad_r[i-1][HRW-1 -: 2]};
      trial = {2'b00, hs_root_r[i-1], 2'b01};
      diff  = tmp - trial;
      ge    = (tmp >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hs_vld_r[i] <= 1'b0;
      end else begin
        hs_vld_r[i] <= hs_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      hs_sd_r[i]   <= hs_sd_r[i-1];
      hs_rad_r[i]  <= {hs_rad_r[i-1][HRW-3:0], 2'b00};
      hs_root_r[i] <= {hs_root_r[i-1][RW-2:0], ge};
      hs_rem_r[i]  <= ge ? diff[RW+1:0] : tmp[RW+1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage g1: products a*dx, a*dy, h*dx, h*dy
  logic                 g1_vld_r;
  hsd_t                 g1_sd_r;
  logic signed [PW-1:0] g1_prod_r [0:3];
  logic signed [PW-1:0] g1_prod_nxt [0:3];
  hsd_t                 g1_sd_nxt;
  logic [RW:0]          g1_h;

  always_comb begin
    g1_h            = {1'b0, hs_root_r[FN]};
    g1_prod_nxt[0]  = $signed(hs_sd_r[FN].a) * $signed(hs_sd_r[FN].dx);
    g1_prod_nxt[1]  = $signed(hs_sd_r[FN].a) * $signed(hs_sd_r[FN].dy);
    g1_prod_nxt[2]  = $signed(g1_h) * $signed(hs_sd_r[FN].dx);
    g1_prod_nxt[3]  = $signed(g1_h) * $signed(hs_sd_r[FN].dy);
    g1_sd_nxt.ax    = hs_sd_r[FN].ax;
    g1_sd_nxt.ay    = hs_sd_r[FN].ay;
    g1_sd_nxt.d     = hs_sd_r[FN].d;
    g1_sd_nxt.neg   = '0;
    g1_sd_nxt.found = hs_sd_r[FN].found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else begin
      g1_vld_r <= hs_vld_r[FN];
    end
  end

  always_ff @(posedge clk) begin
    g1_sd_r <= g1_sd_nxt;
    for (int k = 0; k < 4; k++) begin
      g1_prod_r[k] <= g1_prod_nxt[k];
    end
  end

  // stage g2: numerators of the four offsets
  logic                 g2_vld_r;
  hsd_t                 g2_sd_r;
  logic signed [MW-1:0] g2_sum_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_vld_r <= 1'b0;
    end else begin
      g2_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    g2_sd_r     <= g1_sd_r;
    g2_sum_r[0] <= MW'(g1_prod_r[0]) + MW'(g1_prod_r[3]);   // first_x
    g2_sum_r[1] <= MW'(g1_prod_r[1]) - MW'(g1_prod_r[2]);   // first_y
    g2_sum_r[2] <= MW'(g1_prod_r[0]) - MW'(g1_prod_r[3]);   // second_x
    g2_sum_r[3] <= MW'(g1_prod_r[1]) + MW'(g1_prod_r[2]);   // second_y
  end

  // ---------------------------------------------------------------------------
  // four offsets divided by d, truncated toward zero; each quotient stays
  // below 2*r1, so the high part of every magnitude starts below d
  logic          pd_vld_r [0:QB];
  hsd_t          pd_sd_r  [0:QB];
  logic [DW-1:0] pd_rem_r [0:QB][0:3];
  logic [QB-1:0] pd_low_r [0:QB][0:3];
  logic [MW-1:0] pd_mag   [0:3];
  hsd_t          pd_sd_nxt;

  always_comb begin
    pd_sd_nxt = g2_sd_r;
    for (int k = 0; k < 4; k++) begin
      pd_sd_nxt.neg[k] = g2_sum_r[k][MW-1];
      pd_mag[k]        = g2_sum_r[k][MW-1] ? -g2_sum_r[k] : g2_sum_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pd_vld_r[0] <= 1'b0;
    end else begin
      pd_vld_r[0] <= g2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pd_sd_r[0] <= pd_sd_nxt;
    for (int k = 0; k < 4; k++) begin
      pd_rem_r[0][k] <= pd_mag[k][QB+DW-1:QB];
      pd_low_r[0][k] <= pd_mag[k][QB-1:0];
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_pt_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pd_vld_r[i] <= 1'b0;
      end else begin
        pd_vld_r[i] <= pd_vld_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      pd_sd_r[i] <= pd_sd_r[i-1];
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
      logic [DW:0] tmp;
      logic [DW:0] dd;
      logic [DW:0] diff;
      logic        ge;

      always_comb begin
        tmp  = {pd_rem_r[i-1][k], pd_low_r[i-1][k][QB-1]};
        dd   = {1'b0, pd_sd_r[i-1].d};
        diff = tmp - dd;
        ge   = (tmp >= dd);
      end

      always_ff @(posedge clk) begin
        pd_rem_r[i][k] <= ge ? diff[DW-1:0] : tmp[DW-1:0];
        pd_low_r[i][k] <= {pd_low_r[i-1][k][QB-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: add the centre, saturate, clear coordinates on a miss
  logic                 out_strobe_r;
  cci_out_t             out_data_r;
  cci_out_t             out_data_nxt;
  logic [CW-1:0]        coord [0:3];
  logic signed [SW-1:0] q_s;
  logic signed [SW-1:0] c_s;
  logic signed [SW-1:0] sum_s;
  logic [CW-1:0]        centre;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      centre = k[0] ? pd_sd_r[QB].ay : pd_sd_r[QB].ax;
      q_s    = pd_sd_r[QB].neg[k] ? -SW'(pd_low_r[QB][k]) : SW'(pd_low_r[QB][k]);
      c_s    = {{(SW-CW){centre[CW-1]}}, centre};
      sum_s  = c_s + q_s;
      if (sum_s > CMAX) begin
        coord[k] = CMAX[CW-1:0];
      end else if (sum_s < CMIN) begin
        coord[k] = CMIN[CW-1:0];
      end else begin
        coord[k] = sum_s[CW-1:0];
      end
    end
    out_data_nxt.found = pd_sd_r[QB].found;
    if (pd_sd_r[QB].found) begin
      out_data_nxt.first_x  = coord[0];
      out_data_nxt.first_y  = coord[1];
      out_data_nxt.second_x = coord[2];
      out_data_nxt.second_y = coord[3];
    end else begin
      out_data_nxt.first_x  = '0;
      out_data_nxt.first_y  = '0;
      out_data_nxt.second_x = '0;
      out_data_nxt.second_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= pd_vld_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule
